// ===== rtl/core/ibrle_pkg.sv =====
// Package for the interleaved bit-plane run-length unpacker.
// Holds decode phase, status codes, register indexes and geometry limits.
// No dependencies.
package ibrle_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_RUN     = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_SHORT    = 2'd2,
        ST_MODE     = 2'd3
    } status_t;

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_PLANES = 3'd2;
    localparam logic [2:0] CFG_MASK   = 3'd3;
    localparam logic [2:0] CFG_MODE   = 3'd4;
    localparam logic [2:0] CFG_BODY   = 3'd5;

    localparam logic [7:0] MODE_NONE = 8'd0;
    localparam logic [7:0] MODE_RLE  = 8'd1;
    localparam logic [7:0] HDR_SKIP  = 8'h80;

    localparam logic [4:0]  MAX_PLANES = 5'd9;
    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    localparam logic [13:0] RST_WIDTH  = 14'd320;
    localparam logic [12:0] RST_HEIGHT = 13'd200;
    localparam logic [3:0]  RST_PLANES = 4'd5;

    typedef struct packed {
        logic       emit;
        logic       fail;
        status_t    code;
        logic [7:0] val;
        logic [7:0] cnt;
        logic       dec_body;
        logic       set_lit;
        logic       set_run;
        logic [7:0] hdr_cnt;
    } dec_t;

endpackage

// ===== rtl/core/interleaved_bitplane_rle_unpacker_top.sv =====
// Interleaved bit-plane run-length unpacker, top level.
// Decodes body bytes into plane-row writes; depends on ibrle_pkg.
//
//  channel  | direction | tdata                         | tuser  | tlast
//  s_       | in        | body_byte                     | -      | -
//  m_       | out       | pixel,count,plane,row,offset  | status | picture_done
//  cfg_     | in        | write enable, index, data     | -      | -
//
// One body byte per cycle while s_tready is high; each byte is decoded in the cycle it is accepted.
// A result appears in the cycle after its byte is accepted, held in the output register.
// s_tready drops only while a result waits and m_tready is low.
// Reset is synchronous; no clearing pass, the block is ready right after reset.
// A write to body_size restarts decoding of a new picture.
module interleaved_bitplane_rle_unpacker_top #(
    parameter int MAX_ROW_BYTES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] body_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // [7:0] pixel_byte, [15:8] repeat_count,
                                     // [19:16] plane_index, [31:20] row_index,
                                     // [41:32] byte_offset, [47:42] zero
    output logic [1:0]  m_tuser,     // [1:0] status
    output logic        m_tlast,     // picture_done
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wr_data
);
    import ibrle_pkg::*;

    localparam int RW = (MAX_ROW_BYTES > 2) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int BW = RW + 1;
    localparam int SW = ((RW > 8) ? RW : 8) + 1;
    localparam logic [12:0] MAX_RB = 13'(MAX_ROW_BYTES);

    logic [13:0] width_reg;
    logic [12:0] height_reg;
    logic [3:0]  planes_reg;
    logic        mask_reg;
    logic [7:0]  mode_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  lit_reg, lit_next;
    logic [7:0]  run_reg, run_next;
    logic [RW-1:0] row_pos_reg, row_pos_next;
    logic [3:0]  plane_reg, plane_next;
    logic [11:0] row_y_reg, row_y_next;
    logic [23:0] body_reg, body_next;
    status_t     err_reg, err_next;
    logic        fin_reg, fin_next;

    logic        out_valid_reg;
    logic [7:0]  out_val_reg, out_cnt_reg;
    logic [3:0]  out_plane_reg;
    logic [11:0] out_row_reg;
    logic [9:0]  out_off_reg;
    logic        out_last_reg;
    status_t     out_st_reg;
    logic        done_next;

    logic        take, restart;
    dec_t        dec;

    logic [13:0] w_eff;
    logic [14:0] w_sum;
    logic [11:0] bpr_raw;
    logic [BW-1:0] bpr;
    logic [4:0]  depth_raw;
    logic [4:0]  depth;
    logic [12:0] height;
    logic [BW-1:0] rem;
    logic [7:0]  lit_dec;
    logic [23:0] body_dec;
    logic [SW-1:0] pos_sum;

    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready && !fin_reg && (err_reg == ST_OK);
    assign restart  = cfg_wr_en && (cfg_addr == CFG_BODY);

    assign w_eff   = (width_reg == 14'd0) ? 14'd1 : width_reg;
    assign w_sum   = {1'b0, w_eff} + 15'd15;
    assign bpr_raw = {w_sum[14:4], 1'b0};
    assign bpr     = ({1'b0, bpr_raw} > MAX_RB) ? BW'(MAX_RB) : BW'(bpr_raw);

    assign depth_raw = {1'b0, planes_reg} + {4'd0, mask_reg};
    assign depth     = (depth_raw == 5'd0) ? 5'd1 :
                       (depth_raw > MAX_PLANES) ? MAX_PLANES : depth_raw;
    assign height    = (height_reg == 13'd0) ? 13'd1 :
                       (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;

    assign rem      = (BW'(row_pos_reg) < bpr) ? (bpr - BW'(row_pos_reg)) : '0;
    assign lit_dec  = (lit_reg != 8'd0) ? (lit_reg - 8'd1) : 8'd0;
    assign body_dec = body_reg - 24'd1;

    // Classify the accepted byte.
    always_comb begin
        dec = '0;
        dec.code = ST_OK;
        if (mode_reg > MODE_RLE) begin
            dec.fail = 1'b1;
            dec.code = ST_MODE;
        end else if (mode_reg == MODE_NONE) begin
            if (body_reg == 24'd0 ||
                (row_pos_reg == '0 && body_reg < 24'(bpr))) begin
                dec.fail = 1'b1;
                dec.code = ST_SHORT;
            end else begin
                dec.dec_body = 1'b1;
                dec.emit     = 1'b1;
                dec.val      = s_tdata;
                dec.cnt      = 8'd1;
            end
        end else if (body_reg == 24'd0) begin
            dec.fail = 1'b1;
            dec.code = ST_SHORT;
        end else begin
            dec.dec_body = 1'b1;
            unique case (phase_reg)
                PH_LITERAL: begin
                    dec.emit = 1'b1;
                    dec.val  = s_tdata;
                    dec.cnt  = 8'd1;
                end
                PH_RUN: begin
                    dec.emit = 1'b1;
                    dec.val  = s_tdata;
                    dec.cnt  = run_reg;
                end
                default: begin
                    if (s_tdata[7] == 1'b0) begin
                        dec.hdr_cnt = {1'b0, s_tdata[6:0]} + 8'd1;
                        if (body_dec < 24'(dec.hdr_cnt)) begin
                            dec.fail = 1'b1;
                            dec.code = ST_SHORT;
                        end else if (SW'(rem) < SW'(dec.hdr_cnt)) begin
                            dec.fail = 1'b1;
                            dec.code = ST_OVERFLOW;
                        end else begin
                            dec.set_lit = 1'b1;
                        end
                    end else if (s_tdata != HDR_SKIP) begin
                        dec.hdr_cnt = 8'(9'd257 - {1'b0, s_tdata});
                        if (body_dec == 24'd0) begin
                            dec.fail = 1'b1;
                            dec.code = ST_SHORT;
                        end else if (SW'(rem) < SW'(dec.hdr_cnt)) begin
                            dec.fail = 1'b1;
                            dec.code = ST_OVERFLOW;
                        end else begin
                            dec.set_run = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    // Decode phase.
    always_comb begin
        phase_next = phase_reg;
        if (restart) begin
            phase_next = PH_HEADER;
        end else if (take && mode_reg == MODE_NONE) begin
            phase_next = PH_HEADER;
        end else if (take && mode_reg == MODE_RLE && body_reg != 24'd0) begin
            unique case (phase_reg)
                PH_LITERAL: if (lit_dec == 8'd0) phase_next = PH_HEADER;
                PH_RUN:     phase_next = PH_HEADER;
                default: begin
                    if (dec.set_lit) phase_next = PH_LITERAL;
                    else if (dec.set_run) phase_next = PH_RUN;
                end
            endcase
        end
    end

    // Counters, position and error.
    always_comb begin
        lit_next     = lit_reg;
        run_next     = run_reg;
        row_pos_next = row_pos_reg;
        plane_next   = plane_reg;
        row_y_next   = row_y_reg;
        body_next    = body_reg;
        err_next     = err_reg;
        fin_next     = fin_reg;
        done_next    = 1'b0;
        pos_sum      = SW'(row_pos_reg) + SW'(dec.cnt);
        if (restart) begin
            lit_next     = 8'd0;
            run_next     = 8'd0;
            row_pos_next = '0;
            plane_next   = 4'd0;
            row_y_next   = 12'd0;
            body_next    = cfg_wr_data;
            err_next     = ST_OK;
            fin_next     = 1'b0;
        end else if (take) begin
            if (dec.dec_body) body_next = body_dec;
            if (dec.fail) err_next = dec.code;
            if (mode_reg == MODE_RLE && phase_reg == PH_LITERAL && body_reg != 24'd0)
                lit_next = lit_dec;
            if (dec.set_lit) lit_next = dec.hdr_cnt;
            if (dec.set_run) run_next = dec.hdr_cnt;
            if (dec.emit) begin
                row_pos_next = RW'(pos_sum);
                if (pos_sum >= SW'(bpr)) begin
                    row_pos_next = '0;
                    plane_next   = plane_reg + 4'd1;
                    if ({1'b0, plane_reg} + 5'd1 >= depth) begin
                        plane_next = 4'd0;
                        row_y_next = row_y_reg + 12'd1;
                        if ({1'b0, row_y_reg} + 13'd1 >= height) begin
                            fin_next  = 1'b1;
                            done_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= RST_WIDTH;
            height_reg    <= RST_HEIGHT;
            planes_reg    <= RST_PLANES;
            mask_reg      <= 1'b0;
            mode_reg      <= MODE_RLE;
            phase_reg     <= PH_HEADER;
            lit_reg       <= 8'd0;
            run_reg       <= 8'd0;
            row_pos_reg   <= '0;
            plane_reg     <= 4'd0;
            row_y_reg     <= 12'd0;
            body_reg      <= 24'd0;
            err_reg       <= ST_OK;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_WIDTH:  width_reg  <= cfg_wr_data[13:0];
                    CFG_HEIGHT: height_reg <= cfg_wr_data[12:0];
                    CFG_PLANES: planes_reg <= cfg_wr_data[3:0];
                    CFG_MASK:   mask_reg   <= cfg_wr_data[0];
                    CFG_MODE:   mode_reg   <= cfg_wr_data[7:0];
                    default: ;
                endcase
            end
            phase_reg   <= phase_next;
            lit_reg     <= lit_next;
            run_reg     <= run_next;
            row_pos_reg <= row_pos_next;
            plane_reg   <= plane_next;
            row_y_reg   <= row_y_next;
            body_reg    <= body_next;
            err_reg     <= err_next;
            fin_reg     <= fin_next;
            if (take && (dec.emit || dec.fail)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register: load on an item that produces a write or an error.
    always_ff @(posedge aclk) begin
        if (take && (dec.emit || dec.fail)) begin
            out_val_reg   <= dec.val;
            out_cnt_reg   <= dec.cnt;
            out_plane_reg <= plane_reg;
            out_row_reg   <= row_y_reg;
            out_off_reg   <= 10'(row_pos_reg);
            out_last_reg  <= done_next;
            out_st_reg    <= dec.code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_off_reg, out_row_reg, out_plane_reg, out_cnt_reg, out_val_reg};
    assign m_tuser  = out_st_reg;
    assign m_tlast  = out_last_reg;

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while result stalled");

    a_err_fin_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(err_reg != ST_OK && fin_reg))
        else $error("error and completion both set");

    a_lit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LITERAL) |-> (lit_reg != 8'd0))
        else $error("literal phase with no literal left");

    a_last_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == ST_OK && m_tdata[15:8] != 8'd0))
        else $error("picture end on a status item");

endmodule

// ===== tb/plane_write_checker.sv =====
// Checker for the interleaved bit-plane run-length unpacker: watches the body byte,
// result and register write channels, predicts every plane-row write and compares it.
// Depends on ibrle_pkg for phase, status and register codes.
module plane_write_checker #(
    parameter int MAX_ROW_BYTES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wr_data,
    output int          pending_writes,
    output int          error_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ibrle_pkg::*;

    typedef struct packed {
        logic [7:0]  pixel;
        logic [7:0]  count;
        logic [3:0]  plane;
        logic [11:0] row;
        logic [9:0]  offset;
        logic        done;
        status_t     status;
    } plane_write_t;

    logic [13:0] img_width;
    logic [12:0] img_height;
    logic [3:0]  n_planes;
    logic        mask_on;
    logic [7:0]  mode;
    logic [23:0] body_len;

    phase_t  phase;
    int      lit_left;
    int      run_len;
    int      col;
    int      plane;
    int      row;
    int      body_left;
    status_t err;
    bit      pic_done;
    int      fails = 0;

    plane_write_t expected_writes[$];

    function automatic int row_bytes();
        int w;
        int b;
        w = (img_width == 0) ? 1 : int'(img_width);
        b = ((w + 15) >> 4) << 1;
        return (b > MAX_ROW_BYTES) ? MAX_ROW_BYTES : b;
    endfunction

    function automatic void restart();
        phase     = PH_HEADER;
        lit_left  = 0;
        run_len   = 0;
        col       = 0;
        plane     = 0;
        row       = 0;
        body_left = int'(body_len);
        err       = ST_OK;
        pic_done  = 1'b0;
    endfunction

    function automatic plane_write_t at_position(int val, int cnt, status_t st);
        plane_write_t w;
        w.pixel  = 8'(val);
        w.count  = 8'(cnt);
        w.plane  = 4'(plane);
        w.row    = 12'(row);
        w.offset = 10'(col);
        w.done   = 1'b0;
        w.status = st;
        return w;
    endfunction

    function automatic plane_write_t flag_error(status_t st);
        err = st;
        return at_position(0, 0, st);
    endfunction

    function automatic plane_write_t write_at(int val, int cnt);
        plane_write_t w;
        int depth;
        int hgt;
        w = at_position(val, cnt, ST_OK);
        col += cnt;
        if (col >= row_bytes()) begin
            col = 0;
            plane++;
            depth = int'(n_planes) + int'(mask_on);
            if (depth == 0) depth = 1;
            if (depth > int'(MAX_PLANES)) depth = int'(MAX_PLANES);
            if (plane >= depth) begin
                plane = 0;
                row++;
                hgt = (img_height == 0) ? 1 : int'(img_height);
                if (hgt > int'(MAX_HEIGHT)) hgt = int'(MAX_HEIGHT);
                if (row >= hgt) begin
                    pic_done = 1'b1;
                    w.done   = 1'b1;
                end
            end
        end
        return w;
    endfunction

    function automatic bit predict_write(input logic [7:0] b, output plane_write_t w);
        int bpr;
        int rem;
        int cnt;
        if (pic_done || err != ST_OK) return 1'b0;
        if (mode > MODE_RLE) begin
            w = flag_error(ST_MODE);
            return 1'b1;
        end
        bpr = row_bytes();
        rem = (col < bpr) ? bpr - col : 0;
        if (mode == MODE_NONE) begin
            phase = PH_HEADER;
            if (body_left == 0 || (col == 0 && body_left < bpr)) begin
                w = flag_error(ST_SHORT);
                return 1'b1;
            end
            body_left--;
            w = write_at(b, 1);
            return 1'b1;
        end
        if (body_left == 0) begin
            w = flag_error(ST_SHORT);
            return 1'b1;
        end
        body_left--;
        if (phase == PH_LITERAL) begin
            if (lit_left > 0) lit_left--;
            if (lit_left == 0) phase = PH_HEADER;
            w = write_at(b, 1);
            return 1'b1;
        end
        if (phase == PH_RUN) begin
            phase = PH_HEADER;
            w = write_at(b, run_len);
            return 1'b1;
        end
        if (b < 8'd128) begin
            cnt = int'(b) + 1;
            if (body_left < cnt) begin
                w = flag_error(ST_SHORT);
                return 1'b1;
            end
            if (rem < cnt) begin
                w = flag_error(ST_OVERFLOW);
                return 1'b1;
            end
            lit_left = cnt;
            phase    = PH_LITERAL;
            return 1'b0;
        end
        if (b == HDR_SKIP) return 1'b0;
        cnt = 257 - int'(b);
        if (body_left < 1) begin
            w = flag_error(ST_SHORT);
            return 1'b1;
        end
        if (rem < cnt) begin
            w = flag_error(ST_OVERFLOW);
            return 1'b1;
        end
        run_len = cnt;
        phase   = PH_RUN;
        return 1'b0;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin
        plane_write_t got;
        plane_write_t want;
        plane_write_t next_write;
        if (!aresetn) begin
            img_width  = RST_WIDTH;
            img_height = RST_HEIGHT;
            n_planes   = RST_PLANES;
            mask_on    = 1'b0;
            mode       = MODE_RLE;
            body_len   = '0;
            restart();
            expected_writes.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.pixel  = m_tdata[7:0];
                got.count  = m_tdata[15:8];
                got.plane  = m_tdata[19:16];
                got.row    = m_tdata[31:20];
                got.offset = m_tdata[41:32];
                got.done   = m_tlast;
                got.status = status_t'(m_tuser);
                if (expected_writes.size() == 0) begin
                    $error("unexpected write: row %0d plane %0d offset %0d status %0d",
                           got.row, got.plane, got.offset, got.status);
                    fails++;
                end else begin
                    want = expected_writes.pop_front();
                    check_field("pixel_byte", want.pixel, got.pixel);
                    check_field("repeat_count", want.count, got.count);
                    check_field("plane_index", want.plane, got.plane);
                    check_field("row_index", want.row, got.row);
                    check_field("byte_offset", want.offset, got.offset);
                    check_field("picture_done", want.done, got.done);
                    check_field("status", want.status, got.status);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_WIDTH:  img_width  = cfg_wr_data[13:0];
                    CFG_HEIGHT: img_height = cfg_wr_data[12:0];
                    CFG_PLANES: n_planes   = cfg_wr_data[3:0];
                    CFG_MASK:   mask_on    = cfg_wr_data[0];
                    CFG_MODE:   mode       = cfg_wr_data[7:0];
                    CFG_BODY: begin
                        body_len = cfg_wr_data;
                        restart();
                    end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (predict_write(s_tdata, next_write)) expected_writes.push_back(next_write);
            end
        end
        pending_writes <= expected_writes.size();
        error_count    <= fails;
    end

endmodule

// ===== tb/interleaved_bitplane_rle_unpacker_top_tb.sv =====
// Testbench top for the interleaved bit-plane run-length unpacker: drives body bytes,
// register writes and receiver stalls, then reports the verdict of plane_write_checker.
// Depends on ibrle_pkg, the unpacker top level and plane_write_checker.
module interleaved_bitplane_rle_unpacker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ibrle_pkg::*;

    localparam int ROW_BYTES_MAX = 1024;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 700;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en   = 1'b0;
    logic [2:0]  cfg_addr    = '0;
    logic [23:0] cfg_wr_data = '0;

    int pending_writes;
    int error_count;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int cycle_count   = 0;

    logic [7:0] body_bytes[$];

    interleaved_bitplane_rle_unpacker_top #(
        .MAX_ROW_BYTES(ROW_BYTES_MAX)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    plane_write_checker #(
        .MAX_ROW_BYTES(ROW_BYTES_MAX)
    ) write_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .pending_writes(pending_writes),
        .error_count   (error_count)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("interleaved_bitplane_rle_unpacker_top test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_writes != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input int val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= 24'(val);
        @(posedge aclk);
    endtask

    task automatic cfg_update(input logic [2:0] idx, input int val);
        wait_idle();
        cfg_write(idx, val);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_picture(input int w, input int h, input int p, input int m,
                               input int md, input int body);
        wait_idle();
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_HEIGHT, h);
        cfg_write(CFG_PLANES, p);
        cfg_write(CFG_MASK, m);
        cfg_write(CFG_MODE, md);
        cfg_write(CFG_BODY, body);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void build_rle_body(input int bpr, input int plane_rows,
                                           input int lit_pct, input int lit_max);
        int rem;
        int cnt;
        body_bytes.delete();
        repeat (plane_rows) begin
            rem = bpr;
            while (rem > 0) begin
                if ($urandom_range(9) == 0) begin
                    body_bytes.push_back(HDR_SKIP);
                end else if (rem == 1 || $urandom_range(99) < lit_pct) begin
                    cnt = $urandom_range(1, (rem < lit_max) ? rem : lit_max);
                    body_bytes.push_back(8'(cnt - 1));
                    repeat (cnt) body_bytes.push_back(8'($urandom));
                    rem -= cnt;
                end else begin
                    cnt = $urandom_range(2, (rem < 128) ? rem : 128);
                    body_bytes.push_back(8'(257 - cnt));
                    body_bytes.push_back(8'($urandom));
                    rem -= cnt;
                end
            end
        end
    endfunction

    initial begin
        int items_sent;
        int pic;
        int kind;
        bit big;
        int width;
        int height;
        int planes;
        int mask;
        int bpr;
        int plane_rows;
        int md;
        int len;
        int body_len;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_picture(16, 1, 1, 0, MODE_RLE, 9);
        send_byte(HDR_SKIP);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);

        set_picture(32, 2, 1, 1, MODE_RLE, 20);
        send_byte(8'hFD);
        send_byte(8'hAA);
        send_byte(8'h81);
        send_byte(8'h33);

        set_picture(16, 1, 1, 0, MODE_RLE, 2);
        send_byte(8'h7F);

        set_picture(16, 4, 1, 0, MODE_RLE, 1);
        send_byte(8'hFF);
        send_byte(8'h01);

        set_picture(16, 4, 1, 0, MODE_RLE, 0);
        send_byte(8'h00);

        set_picture(16, 1, 1, 0, 8'hFF, 5);
        send_byte(8'h5A);

        set_picture(8192, 1, 1, 0, MODE_NONE, 100);
        send_byte(8'hA5);

        set_picture(0, 0, 0, 0, MODE_RLE, 24'hFFFFFF);
        send_byte(8'hFF);
        send_byte(8'h55);

        set_picture(16383, 8191, 15, 1, MODE_RLE, 24'hFFFFFF);
        send_byte(8'h81);
        send_byte(8'h12);
        send_byte(8'h01);
        send_byte(8'h34);
        cfg_update(CFG_WIDTH, 16);
        send_byte(8'h56);
        cfg_update(CFG_WIDTH, 16383);
        send_byte(8'h81);
        send_byte(8'h77);
        cfg_update(CFG_WIDTH, 16);
        send_byte(8'h00);

        set_picture(64, 2, 1, 0, MODE_RLE, 50);
        send_byte(8'h03);
        send_byte(8'h11);
        cfg_update(CFG_MODE, MODE_NONE);
        send_byte(8'h22);
        send_byte(8'h33);

        items_sent = 0;
        pic = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case (pic % 4)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct  = 59;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 59;
                end
                default: begin
                    src_idle_pct  = 26;
                    snk_stall_pct = 26;
                end
            endcase
            kind       = $urandom_range(9);
            big        = ($urandom_range(7) == 0);
            width      = big ? $urandom_range(17, 8192) : $urandom_range(1, 48);
            height     = big ? 1 : $urandom_range(1, 3);
            planes     = big ? 1 : $urandom_range(1, 8);
            mask       = $urandom_range(1);
            bpr        = ((width + 15) >> 4) << 1;
            plane_rows = (planes + mask) * height;
            if (kind == 9) begin
                md = $urandom_range(1) ? $urandom_range(0, 1) : $urandom_range(2, 255);
                set_picture($urandom_range(0, 16383), $urandom_range(0, 8191),
                            $urandom_range(0, 15), mask, md,
                            ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 40));
                repeat ($urandom_range(4, 16)) begin
                    send_byte(8'($urandom));
                    items_sent++;
                end
            end else begin
                if (kind == 7 && !big) begin
                    md = MODE_NONE;
                    body_bytes.delete();
                    repeat (bpr * plane_rows) body_bytes.push_back(8'($urandom));
                end else begin
                    md = MODE_RLE;
                    build_rle_body(bpr, plane_rows, big ? 5 : 40, big ? 4 : 128);
                end
                len = body_bytes.size();
                if (kind == 8) begin
                    body_len = $urandom_range(0, len);
                    body_bytes[$urandom_range(0, len - 1)] = 8'($urandom);
                end else begin
                    body_len = len + $urandom_range(0, 2);
                end
                set_picture(width, height, planes, mask, md, body_len);
                foreach (body_bytes[i]) begin
                    if ($urandom_range(49) == 0) wait_idle();
                    send_byte(body_bytes[i]);
                    items_sent++;
                end
                repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
            end
            pic++;
        end

        wait_idle();
        repeat (5) @(posedge aclk);
        if (error_count == 0) begin
            $display("interleaved_bitplane_rle_unpacker_top test passed");
        end else begin
            $display("interleaved_bitplane_rle_unpacker_top test failed");
        end
        $finish;
    end

endmodule
